[rtl/status_led_pattern_controller_macros.svh]
// Assertion macros used by the status LED controller checker.
`ifndef STATUS_LED_PATTERN_CONTROLLER_MACROS_SVH
`define STATUS_LED_PATTERN_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset.
`define SLPC_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("slpc: check failed");

// Next-cycle implication, sampled on i_clk, quiet during reset.
`define SLPC_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("slpc: check failed");

`endif

[rtl/slpc_pkg.sv]
// Types, codes and color constants of the status LED pattern controller.
package slpc_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_SET_STATE = 2'd1;
    localparam logic [1:0] OP_NOTIFY    = 2'd2;

    // system state codes
    localparam logic [2:0] ST_OFF     = 3'd0;
    localparam logic [2:0] ST_BOOTING = 3'd1;
    localparam logic [2:0] ST_ERROR   = 3'd2;
    localparam logic [2:0] ST_DAY     = 3'd3;
    localparam logic [2:0] ST_NIGHT   = 3'd4;

    // brightness in percent
    localparam int unsigned PctNotify = 40;
    localparam int unsigned PctError  = 80;
    localparam int unsigned PctBoot   = 20;
    localparam int unsigned PctDay    = 5;
    localparam int unsigned FullScale = 255;

    // floor(x / 100) = (x * DivRecip) >> DivShift for x up to 255 * 100
    localparam int unsigned DivRecip  = 5243;
    localparam int unsigned DivShift  = 19;
    localparam int unsigned NotifyMul = PctNotify * DivRecip;
    localparam int unsigned MulW      = 27;

    localparam logic [7:0] BootLvl  = 8'(FullScale * PctBoot / 100);
    localparam logic [7:0] ErrorLvl = 8'(FullScale * PctError / 100);
    localparam logic [7:0] DayLvl   = 8'(FullScale * PctDay / 100);

    localparam logic [23:0] RgbBoot  = {BootLvl, BootLvl, 8'd0};
    localparam logic [23:0] RgbError = {ErrorLvl, 16'd0};
    localparam logic [23:0] RgbDay   = {8'd0, DayLvl, 8'd0};
    localparam logic [23:0] RgbDark  = 24'd0;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] new_state;
        logic [7:0] notify_red;
        logic [7:0] notify_green;
        logic [7:0] notify_blue;
        logic [7:0] blink_count;
    } t_item;

    typedef struct packed {
        logic       color_written;
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic       request_accepted;
    } t_result;

endpackage

[rtl/slpc_scale.sv]
// Scales a notify color to the blink brightness with a reciprocal multiply.
module slpc_scale import slpc_pkg::*; (
    input  logic [23:0] i_rgb,
    output logic [23:0] o_rgb
);

    logic [MulW-1:0] w_prod [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_prod[k] = MulW'(i_rgb[8*k +: 8]) * MulW'(NotifyMul);
            o_rgb[8*k +: 8] = w_prod[k][DivShift +: 8];
        end
    end

endmodule

[rtl/slpc_core.sv]
// LED sequencing state and the per-transaction step logic.
module slpc_core import slpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_debug_enable,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    logic        r_debug_enable,     n_debug_enable;
    logic [2:0]  r_system_state,     n_system_state;
    logic [2:0]  r_previous_state,   n_previous_state;
    logic        r_tick_parity,      n_tick_parity;
    logic        r_error_phase_on,   n_error_phase_on;
    logic        r_override_phase,   n_override_phase;
    logic        r_override_ended,   n_override_ended;
    logic        r_override_restart, n_override_restart;
    logic [7:0]  r_blinks_remaining, n_blinks_remaining;
    logic [23:0] r_override_rgb,     n_override_rgb;
    logic [23:0] r_shown_rgb,        n_shown_rgb;

    logic [23:0] w_override_scaled;
    logic        w_changed;
    logic        w_written;
    logic        w_accepted;
    logic        w_phase;

    slpc_scale u_scale (
        .i_rgb (r_override_rgb),
        .o_rgb (w_override_scaled)
    );

    assign w_changed = (r_system_state != r_previous_state) || r_override_ended;
    // a pending restart forces the on phase
    assign w_phase   = r_override_restart ? 1'b0 : r_override_phase;

    always_comb begin
        n_debug_enable     = i_cfg_we ? i_cfg_debug_enable : r_debug_enable;
        n_system_state     = r_system_state;
        n_previous_state   = r_previous_state;
        n_tick_parity      = r_tick_parity;
        n_error_phase_on   = r_error_phase_on;
        n_override_phase   = r_override_phase;
        n_override_ended   = r_override_ended;
        n_override_restart = r_override_restart;
        n_blinks_remaining = r_blinks_remaining;
        n_override_rgb     = r_override_rgb;
        n_shown_rgb        = r_shown_rgb;
        w_written          = 1'b0;
        w_accepted         = 1'b1;

        case (i_item.op)
            OP_TICK: begin
                if (r_blinks_remaining != 8'd0) begin
                    n_override_ended   = 1'b1;
                    n_override_restart = 1'b0;
                    w_written          = 1'b1;
                    if (!w_phase) begin
                        n_shown_rgb      = w_override_scaled;
                        n_override_phase = 1'b1;
                    end else begin
                        n_shown_rgb        = RgbDark;
                        n_override_phase   = 1'b0;
                        n_blinks_remaining = r_blinks_remaining - 8'd1;
                    end
                end else begin
                    n_tick_parity = ~r_tick_parity;
                    if (w_changed) begin
                        n_tick_parity    = 1'b0;
                        n_error_phase_on = 1'b1;
                        n_previous_state = r_system_state;
                        n_override_ended = 1'b0;
                    end
                    case (r_system_state)
                        ST_BOOTING: begin
                            if (w_changed) begin
                                n_shown_rgb = RgbBoot;
                                w_written   = 1'b1;
                            end
                        end
                        ST_ERROR: begin
                            // flash every second tick, or at once on entry
                            if (w_changed || !n_tick_parity) begin
                                n_shown_rgb      = n_error_phase_on ? RgbError : RgbDark;
                                n_error_phase_on = ~n_error_phase_on;
                                w_written        = 1'b1;
                            end
                        end
                        ST_DAY: begin
                            if (w_changed) begin
                                n_shown_rgb = RgbDay;
                                w_written   = 1'b1;
                            end
                        end
                        default: begin
                            if (w_changed) begin
                                n_shown_rgb = RgbDark;
                                w_written   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            OP_SET_STATE: begin
                n_system_state = i_item.new_state;
            end
            OP_NOTIFY: begin
                if (r_system_state == ST_BOOTING) begin
                    w_accepted = 1'b0;
                end else if (r_debug_enable) begin
                    n_override_rgb     = {i_item.notify_red, i_item.notify_green,
                                          i_item.notify_blue};
                    n_override_restart = 1'b1;
                    n_blinks_remaining = i_item.blink_count;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result = '{
        color_written:    w_written,
        led_red:          n_shown_rgb[23:16],
        led_green:        n_shown_rgb[15:8],
        led_blue:         n_shown_rgb[7:0],
        request_accepted: w_accepted
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debug_enable     <= 1'b1;
            r_system_state     <= ST_OFF;
            r_previous_state   <= ST_OFF;
            r_tick_parity      <= 1'b0;
            r_error_phase_on   <= 1'b0;
            r_override_phase   <= 1'b0;
            r_override_ended   <= 1'b0;
            r_override_restart <= 1'b0;
            r_blinks_remaining <= 8'd0;
            r_override_rgb     <= 24'd0;
            r_shown_rgb        <= RgbDark;
        end else begin
            r_debug_enable <= n_debug_enable;
            if (i_step) begin
                r_system_state     <= n_system_state;
                r_previous_state   <= n_previous_state;
                r_tick_parity      <= n_tick_parity;
                r_error_phase_on   <= n_error_phase_on;
                r_override_phase   <= n_override_phase;
                r_override_ended   <= n_override_ended;
                r_override_restart <= n_override_restart;
                r_blinks_remaining <= n_blinks_remaining;
                r_override_rgb     <= n_override_rgb;
                r_shown_rgb        <= n_shown_rgb;
            end
        end
    end

endmodule

[rtl/status_led_pattern_controller.sv]
// RGB status LED sequencer: takes ticks, state changes and notify requests,
// returns one LED result per transaction.
//
// Input channel: i_in_valid / o_in_ready with i_op, i_new_state, the notify
// color and i_blink_count. Output channel: o_out_valid / i_out_ready with the
// write flag, the driven color and the notify acceptance flag. Configuration:
// i_cfg_valid / o_cfg_ready writes i_cfg_debug_enable; o_cfg_ready is always
// high, and writes are expected only while the block is idle.
//
// An accepted transaction lands in the input register; the step logic then
// updates the LED state and loads the result register once that register is
// free or being drained. One transaction per cycle is sustained while the
// receiver takes every result.
//
// Reset (synchronous, active low) empties both registers, sets the state to
// off with the LED dark and enables debug notifies. When the receiver stalls,
// the result register holds; the input register takes one more transaction
// and then o_in_ready drops until the result is taken.
module status_led_pattern_controller import slpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [2:0] i_new_state,
    input  logic [7:0] i_notify_red,
    input  logic [7:0] i_notify_green,
    input  logic [7:0] i_notify_blue,
    input  logic [7:0] i_blink_count,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_color_written,
    output logic [7:0] o_led_red,
    output logic [7:0] o_led_green,
    output logic [7:0] o_led_blue,
    output logic       o_request_accepted,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_debug_enable
);

    logic    r_in_valid,  n_in_valid;
    t_item   r_item;
    logic    r_out_valid, n_out_valid;
    t_result r_result;
    t_result w_result;
    logic    w_step;
    logic    w_in_fire;

    // advance the held transaction when the result register is free
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_in_valid  = w_in_fire ? 1'b1 : (w_step ? 1'b0 : r_in_valid);
        n_out_valid = w_step ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    slpc_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_debug_enable (i_cfg_debug_enable),
        .i_step             (w_step),
        .i_item             (r_item),
        .o_result           (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item <= '{
                op:           i_op,
                new_state:    i_new_state,
                notify_red:   i_notify_red,
                notify_green: i_notify_green,
                notify_blue:  i_notify_blue,
                blink_count:  i_blink_count
            };
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_color_written    = r_result.color_written;
    assign o_led_red          = r_result.led_red;
    assign o_led_green        = r_result.led_green;
    assign o_led_blue         = r_result.led_blue;
    assign o_request_accepted = r_result.request_accepted;

endmodule

[rtl/slpc_checker.sv]
// Port-level checks of the status LED pattern controller, bound to the top.
`include "status_led_pattern_controller_macros.svh"

module slpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_color_written,
    input logic [7:0] o_led_red,
    input logic [7:0] o_led_green,
    input logic [7:0] o_led_blue,
    input logic       o_request_accepted
);

    logic [25:0] w_payload;

    assign w_payload = {o_color_written, o_led_red, o_led_green, o_led_blue,
                        o_request_accepted};

    // a stalled result stays offered
    `SLPC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // a stalled result keeps its payload
    `SLPC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(w_payload))

    // a draining or empty output side never blocks the input
    `SLPC_ASSERT_NOW(a_in_flow, !o_out_valid || i_out_ready, o_in_ready)

    // a refused notify is not a tick, so it writes no color
    `SLPC_ASSERT_NOW(a_refuse_no_write, o_out_valid && !o_request_accepted, !o_color_written)

endmodule

bind status_led_pattern_controller slpc_checker u_slpc_checker (.*);
